>>> rtl/core/svpf_pkg.sv
// Shared types and constants for the servo write packet framer.
package svpf_pkg;

    // Operation codes of a command beat.
    localparam logic [1:0] OP_GOAL_POSITION = 2'd0;
    localparam logic [1:0] OP_GOAL_SPEED    = 2'd1;
    localparam logic [1:0] OP_SET_ID        = 2'd2;
    localparam logic [1:0] OP_MODE          = 2'd3;

    // Fixed packet bytes.
    localparam logic [7:0] HEADER_BYTE  = 8'hFF;
    localparam logic [7:0] WRITE_INST   = 8'h03;
    localparam logic [7:0] BROADCAST_ID = 8'hFE;

    // Register addresses.
    localparam logic [7:0] ADDR_GOAL_POSITION = 8'd42;
    localparam logic [7:0] ADDR_GOAL_SPEED    = 8'h2E;
    localparam logic [7:0] ADDR_SET_ID        = 8'h05;
    localparam logic [7:0] ADDR_MODE          = 8'd33;

    // Length field values.
    localparam logic [7:0] LEN_GOAL_POSITION = 8'd9;
    localparam logic [7:0] LEN_GOAL_SPEED    = 8'd5;
    localparam logic [7:0] LEN_SHORT         = 8'h04;

    // Body sizes: bytes from the id through the last data byte.
    localparam int unsigned BODY_MAX = 10;
    localparam logic [3:0] BODY_GOAL_POSITION = 4'd10;
    localparam logic [3:0] BODY_GOAL_SPEED    = 4'd6;
    localparam logic [3:0] BODY_SHORT         = 4'd5;

    // Default depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // One command beat.
    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         servo_id;
        logic signed [15:0] position;
        logic signed [15:0] speed;
        logic [7:0]         setting_byte;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } result_t;

    // A classified packet: its body bytes and their count.
    typedef struct packed {
        logic [3:0]                body_count;
        logic [BODY_MAX-1:0][7:0]  body;
    } desc_t;

    // Queue status seen by front and back.
    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

>>> rtl/core/svpf_front.sv
// Front end: accepts a command beat and builds the packet body.
module svpf_front (
    input  logic           start,
    input  svpf_pkg::cmd_t command,
    input  svpf_pkg::qstat_t qstat,
    output logic           push,
    output svpf_pkg::desc_t desc
);

    logic [15:0] magnitude;
    logic [15:0] pos_word;

    // A beat is taken whenever the queue has room.
    assign push = start && !qstat.full;

    // Sign-magnitude form of the goal position.
    always_comb
    begin
        magnitude = 16'd0 - command.position;
        if (command.position[15])
        begin
            pos_word = {1'b1, magnitude[14:0]};
        end
        else
        begin
            pos_word = {1'b0, command.position[14:0]};
        end
    end

    // Body bytes for each kind of packet.
    always_comb
    begin
        desc = '0;
        unique case (command.operation)
            svpf_pkg::OP_GOAL_POSITION:
            begin
                desc.body_count = svpf_pkg::BODY_GOAL_POSITION;
                desc.body[0] = command.servo_id;
                desc.body[1] = svpf_pkg::LEN_GOAL_POSITION;
                desc.body[2] = svpf_pkg::WRITE_INST;
                desc.body[3] = svpf_pkg::ADDR_GOAL_POSITION;
                desc.body[4] = pos_word[7:0];
                desc.body[5] = pos_word[15:8];
                desc.body[6] = 8'd0;
                desc.body[7] = 8'd0;
                desc.body[8] = command.speed[7:0];
                desc.body[9] = command.speed[15:8];
            end
            svpf_pkg::OP_GOAL_SPEED:
            begin
                desc.body_count = svpf_pkg::BODY_GOAL_SPEED;
                desc.body[0] = command.servo_id;
                desc.body[1] = svpf_pkg::LEN_GOAL_SPEED;
                desc.body[2] = svpf_pkg::WRITE_INST;
                desc.body[3] = svpf_pkg::ADDR_GOAL_SPEED;
                desc.body[4] = command.speed[7:0];
                desc.body[5] = command.speed[15:8];
            end
            svpf_pkg::OP_SET_ID:
            begin
                desc.body_count = svpf_pkg::BODY_SHORT;
                desc.body[0] = svpf_pkg::BROADCAST_ID;
                desc.body[1] = svpf_pkg::LEN_SHORT;
                desc.body[2] = svpf_pkg::WRITE_INST;
                desc.body[3] = svpf_pkg::ADDR_SET_ID;
                desc.body[4] = command.setting_byte;
            end
            svpf_pkg::OP_MODE:
            begin
                desc.body_count = svpf_pkg::BODY_SHORT;
                desc.body[0] = command.servo_id;
                desc.body[1] = svpf_pkg::LEN_SHORT;
                desc.body[2] = svpf_pkg::WRITE_INST;
                desc.body[3] = svpf_pkg::ADDR_MODE;
                desc.body[4] = command.setting_byte;
            end
        endcase
    end

endmodule

>>> rtl/core/svpf_queue.sv
// Small first-in first-out queue of classified packets.
module svpf_queue #(
    parameter int unsigned DEPTH = svpf_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  svpf_pkg::desc_t  push_desc,
    input  logic             pop,
    output svpf_pkg::desc_t  pop_desc,
    output svpf_pkg::qstat_t qstat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    svpf_pkg::desc_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Status and head of the queue.
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign pop_desc    = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> rtl/core/svpf_back.sv
// Back end: serializes one packet a byte per cycle and appends the checksum.
module svpf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  svpf_pkg::qstat_t qstat,
    input  svpf_pkg::desc_t  pop_desc,
    output logic             pop,
    output svpf_pkg::result_t result,
    output logic             result_strobe
);

    svpf_pkg::desc_t   cur_reg;
    logic              active_reg;
    logic              active_next;
    logic [3:0]        idx_reg;
    logic [3:0]        idx_next;
    logic [7:0]        sum_reg;
    logic [7:0]        sum_next;
    svpf_pkg::result_t result_reg;
    svpf_pkg::result_t emit;
    logic              strobe_reg;
    logic [3:0]        body_idx;
    logic [3:0]        last_idx;
    logic              in_body;
    logic              is_last;

    // Position of the current byte within the packet.
    assign body_idx = idx_reg - 4'd2;
    assign last_idx = cur_reg.body_count + 4'd2;
    assign in_body  = (idx_reg >= 4'd2) && (idx_reg < last_idx);
    assign is_last  = active_reg && (idx_reg == last_idx);

    // Take the next packet when idle or on the checksum byte of this one.
    assign pop = !qstat.empty && (!active_reg || is_last);

    // Byte selection: header, body, then inverted sum.
    always_comb
    begin
        emit.last_byte = is_last;
        if (idx_reg < 4'd2)
        begin
            emit.tx_byte = svpf_pkg::HEADER_BYTE;
        end
        else if (in_body)
        begin
            emit.tx_byte = cur_reg.body[body_idx];
        end
        else
        begin
            emit.tx_byte = ~sum_reg;
        end
    end

    // Sequencer state updates.
    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = 4'd0;
            sum_next    = 8'd0;
        end
        else if (is_last)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + 4'd1;
            if (in_body)
            begin
                sum_next = sum_reg + emit.tx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 4'd0;
            sum_reg    <= 8'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            sum_reg    <= sum_next;
            strobe_reg <= active_reg;
        end
    end

    // Packet and output payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_desc;
        end
        result_reg <= emit;
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    // The byte index never runs past the checksum byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (idx_reg <= last_idx))
        else $error("byte index beyond checksum");

    // A packet in flight has one of the three legal body sizes.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cur_reg.body_count == svpf_pkg::BODY_GOAL_POSITION ||
                        cur_reg.body_count == svpf_pkg::BODY_GOAL_SPEED ||
                        cur_reg.body_count == svpf_pkg::BODY_SHORT))
        else $error("illegal body size");

    // Packets are never taken from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    // A beat right after a checksum beat opens a new header.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last_byte) |=>
            (!strobe_reg || result_reg.tx_byte == svpf_pkg::HEADER_BYTE))
        else $error("packet did not restart with a header");

endmodule

>>> rtl/core/servo_write_packet_framer.sv
// Top level of the servo write packet framer: front end, queue and serializer.
// A command passes a queue slot and the packet register; bytes leave via an output register.
// A packet streams one byte per cycle: 13 bytes for goal position, 9 for speed, 8 otherwise.
// New commands queue while a packet streams; busy rises only while the packet queue is full.
// A queued command starts the cycle after the previous checksum; results cannot be stalled.
// Reset empties the queue and idles the serializer; slots and data registers are not reset.
module servo_write_packet_framer #(
    parameter int unsigned QUEUE_DEPTH = svpf_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  svpf_pkg::cmd_t     command,
    output svpf_pkg::result_t  result,
    output logic               result_strobe
);

    logic             push;
    logic             pop;
    svpf_pkg::desc_t  push_desc;
    svpf_pkg::desc_t  pop_desc;
    svpf_pkg::qstat_t qstat;

    assign busy = qstat.full;

    // Command classification.
    svpf_front u_front (
        .start   (start),
        .command (command),
        .qstat   (qstat),
        .push    (push),
        .desc    (push_desc)
    );

    // Packet queue between front and back.
    svpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .qstat     (qstat)
    );

    // Byte serializer.
    svpf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .qstat         (qstat),
        .pop_desc      (pop_desc),
        .pop           (pop),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule
